// ----- rtl/core/cpmlu_pkg.sv -----
// shared types, constants and fixed-point helpers for the cpml cell update
package cpmlu_pkg;

    localparam int unsigned FIFO_DEPTH = 8;
    localparam int unsigned FIFO_CW    = 4;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    localparam logic [1:0] REG_CELL_STEP   = 2'd0;
    localparam logic [1:0] REG_INV_STEP    = 2'd1;
    localparam logic [1:0] REG_OUTER_SIDE  = 2'd2;
    localparam logic [1:0] REG_MAGNETIC    = 2'd3;

    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic               opcode;
        logic [11:0]        cell_addr;
        logic [3:0]         layer;
        logic signed [31:0] curl_first;
        logic signed [31:0] curl_second;
        logic signed [31:0] field1_in;
        logic signed [31:0] field2_in;
        logic signed [31:0] cb_first;
        logic signed [31:0] cb_second;
        logic signed [31:0] coef_decay;
        logic signed [31:0] coef_scale;
        logic signed [31:0] coef_kterm;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] field1_out;
        logic signed [31:0] field2_out;
        logic               saturated;
    } out_item_t;

    typedef struct packed {
        logic [30:0] cell_step;
        logic [30:0] inverse_step;
        logic        outer_side;
        logic        magnetic_update;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] v;
        logic               clip;
    } qres_t;

    function automatic qres_t qmul(logic signed [31:0] x, logic signed [31:0] y);
        logic signed [63:0] p;
        qres_t r;
        p = x * y;
        if (p[63:47] == {17{p[63]}})
        begin
            r.v = p[47:16];
            r.clip = 1'b0;
        end
        else
        begin
            r.v = p[63] ? Q_MIN : Q_MAX;
            r.clip = 1'b1;
        end
        return r;
    endfunction

    function automatic qres_t qsat33(logic signed [32:0] s);
        qres_t r;
        if (s[32] == s[31])
        begin
            r.v = s[31:0];
            r.clip = 1'b0;
        end
        else
        begin
            r.v = s[32] ? Q_MIN : Q_MAX;
            r.clip = 1'b1;
        end
        return r;
    endfunction

    function automatic qres_t qadd(logic signed [31:0] x, logic signed [31:0] y);
        return qsat33({x[31], x} + {y[31], y});
    endfunction

    function automatic qres_t qsub(logic signed [31:0] x, logic signed [31:0] y);
        return qsat33({x[31], x} - {y[31], y});
    endfunction

    function automatic qres_t qneg(logic signed [31:0] x, logic en);
        qres_t r;
        r.v = x;
        r.clip = 1'b0;
        if (en)
        begin
            if (x == Q_MIN)
            begin
                r.v = Q_MAX;
                r.clip = 1'b1;
            end
            else
            begin
                r.v = -x;
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/cpmlu_if.sv -----
// request and result channel interfaces
interface cpmlu_req_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [11:0]        cell_addr;
    logic [3:0]         layer;
    logic signed [31:0] curl_first;
    logic signed [31:0] curl_second;
    logic signed [31:0] field1_in;
    logic signed [31:0] field2_in;
    logic signed [31:0] cb_first;
    logic signed [31:0] cb_second;
    logic signed [31:0] coef_decay;
    logic signed [31:0] coef_scale;
    logic signed [31:0] coef_kterm;

    modport source (
        output valid, opcode, cell_addr, layer, curl_first, curl_second,
               field1_in, field2_in, cb_first, cb_second,
               coef_decay, coef_scale, coef_kterm,
        input  ready
    );
    modport sink (
        input  valid, opcode, cell_addr, layer, curl_first, curl_second,
               field1_in, field2_in, cb_first, cb_second,
               coef_decay, coef_scale, coef_kterm,
        output ready
    );
endinterface

interface cpmlu_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] field1_out;
    logic signed [31:0] field2_out;
    logic               saturated;

    modport source (output valid, field1_out, field2_out, saturated, input ready);
    modport sink (input valid, field1_out, field2_out, saturated, output ready);
endinterface

// ----- rtl/core/cpml_cell_update.sv -----
// top level: cpml cell update with apb register port and result queue
// six pipeline stages plus an 8-entry result queue; each request beat yields one result
// throughput: one beat per cycle while credits remain and psi is not being cleared
// psi read-modify-write resolves back-to-back hits on one cell by forwarding
// reset: config registers return to defaults, then each psi entry is cleared in turn,
// during which no request beat is taken
module cpml_cell_update #(
    parameter int unsigned PSI_DEPTH = 4096,
    parameter int unsigned LAYERS    = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    cpmlu_req_if.sink          req,
    cpmlu_rsp_if.source        rsp
);
    import cpmlu_pkg::*;

    cfg_t               cfg_reg;
    logic               wr;
    logic               fire;
    logic               pop;
    logic               clear_busy;
    logic               push;
    out_item_t          push_data;
    out_item_t          head;
    logic               not_empty;
    in_item_t           item;
    logic [FIFO_CW-1:0] credit_reg;
    logic [FIFO_CW-1:0] credit_next;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cell_step       <= 31'd65536;
            cfg_reg.inverse_step    <= 31'd65536;
            cfg_reg.outer_side      <= 1'b0;
            cfg_reg.magnetic_update <= 1'b0;
        end
        else if (wr)
        begin
            unique case (paddr[3:2])
                REG_CELL_STEP:  cfg_reg.cell_step       <= pwdata[30:0];
                REG_INV_STEP:   cfg_reg.inverse_step    <= pwdata[30:0];
                REG_OUTER_SIDE: cfg_reg.outer_side      <= pwdata[0];
                REG_MAGNETIC:   cfg_reg.magnetic_update <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_CELL_STEP:  prdata = {1'b0, cfg_reg.cell_step};
            REG_INV_STEP:   prdata = {1'b0, cfg_reg.inverse_step};
            REG_OUTER_SIDE: prdata = {31'd0, cfg_reg.outer_side};
            REG_MAGNETIC:   prdata = {31'd0, cfg_reg.magnetic_update};
        endcase
    end

    // credits cover beats in the pipeline and in the queue
    assign req.ready = !clear_busy && (credit_reg < FIFO_CW'(FIFO_DEPTH));
    assign fire      = req.valid && req.ready;
    assign pop       = rsp.valid && rsp.ready;

    always_comb
    begin
        credit_next = credit_reg;
        if (fire && !pop)
        begin
            credit_next = credit_reg + 1'b1;
        end
        else if (pop && !fire)
        begin
            credit_next = credit_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
        end
    end

    assign item.opcode      = req.opcode;
    assign item.cell_addr   = req.cell_addr;
    assign item.layer       = req.layer;
    assign item.curl_first  = req.curl_first;
    assign item.curl_second = req.curl_second;
    assign item.field1_in   = req.field1_in;
    assign item.field2_in   = req.field2_in;
    assign item.cb_first    = req.cb_first;
    assign item.cb_second   = req.cb_second;
    assign item.coef_decay  = req.coef_decay;
    assign item.coef_scale  = req.coef_scale;
    assign item.coef_kterm  = req.coef_kterm;

    cpmlu_pipe #(
        .PSI_DEPTH(PSI_DEPTH),
        .LAYERS   (LAYERS)
    ) u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .fire       (fire),
        .item       (item),
        .clear_busy (clear_busy),
        .push       (push),
        .push_data  (push_data)
    );

    cpmlu_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    assign rsp.valid      = not_empty;
    assign rsp.field1_out = head.field1_out;
    assign rsp.field2_out = head.field2_out;
    assign rsp.saturated  = head.saturated;
endmodule

// ----- rtl/core/cpmlu_ram.sv -----
// generic single-write, single-read ram with registered read data
module cpmlu_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- rtl/core/cpmlu_fifo.sv -----
// result queue that decouples the pipeline from the output handshake
module cpmlu_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cpmlu_pkg::out_item_t push_data,
    input  logic                pop,
    output logic                not_empty,
    output cpmlu_pkg::out_item_t head
);
    import cpmlu_pkg::*;

    localparam int unsigned PW = $clog2(FIFO_DEPTH);

    out_item_t            mem_reg [FIFO_DEPTH];
    logic [PW-1:0]        wr_ptr_reg;
    logic [PW-1:0]        rd_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg;
    logic [FIFO_CW-1:0]   count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
endmodule

// ----- rtl/core/cpmlu_pipe.sv -----
// six-stage cpml datapath with coefficient tables and psi store
module cpmlu_pipe #(
    parameter int unsigned PSI_DEPTH = 4096,
    parameter int unsigned LAYERS    = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cpmlu_pkg::cfg_t      cfg,
    input  logic                 fire,
    input  cpmlu_pkg::in_item_t  item,
    output logic                 clear_busy,
    output logic                 push,
    output cpmlu_pkg::out_item_t push_data
);
    import cpmlu_pkg::*;

    localparam int unsigned AW = (PSI_DEPTH > 1) ? $clog2(PSI_DEPTH) : 1;
    localparam int unsigned TW = (LAYERS > 1) ? $clog2(LAYERS) : 1;

    // coefficient tables
    logic signed [31:0] decay_reg [LAYERS];
    logic signed [31:0] scale_reg [LAYERS];
    logic signed [31:0] kterm_reg [LAYERS];

    logic          layer_ok;
    logic          cell_ok;
    logic [TW-1:0] tidx;

    assign layer_ok = (7'(item.layer) < 7'(LAYERS));
    assign cell_ok  = (21'(item.cell_addr) < 21'(PSI_DEPTH));
    assign tidx     = TW'(item.layer);

    always_ff @(posedge clk)
    begin
        if (fire && item.opcode == OP_LOAD && layer_ok)
        begin
            decay_reg[tidx] <= item.coef_decay;
            scale_reg[tidx] <= item.coef_scale;
            kterm_reg[tidx] <= item.coef_kterm;
        end
    end

    // psi clearing pass
    logic          clr_reg;
    logic [AW-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else if (clr_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == AW'(PSI_DEPTH - 1))
            begin
                clr_reg <= 1'b0;
            end
        end
    end

    assign clear_busy = clr_reg;

    // stage registers
    logic               v_reg [1:6];
    logic               op_reg [1:6];
    logic               ok_reg [1:4];
    logic [AW-1:0]      addr_reg [1:4];
    logic signed [31:0] f1_reg [1:6];
    logic signed [31:0] f2_reg [1:6];
    logic signed [31:0] cb1_reg [1:5];
    logic signed [31:0] cb2_reg [1:5];
    logic               clip_reg [2:6];

    logic signed [31:0] s1_c1_reg, s1_c2_reg, s1_b_reg, s1_a_reg, s1_kt_reg;
    logic signed [31:0] s2_ac1_reg, s2_ac2_reg, s2_kc1_reg, s2_kc2_reg, s2_b_reg;
    logic signed [31:0] s3_t1_reg, s3_t2_reg, s3_k1_reg, s3_k2_reg, s3_b_reg;
    logic signed [31:0] s4_p1_reg, s4_p2_reg, s4_k1_reg, s4_k2_reg;
    logic signed [31:0] s5_i1_reg, s5_i2_reg;
    logic signed [31:0] s6_d1_reg, s6_d2_reg;

    // stage 2 logic
    qres_t m_ac1, m_ac2, m_kc1, m_kc2;
    assign m_ac1 = qmul(s1_a_reg, s1_c1_reg);
    assign m_ac2 = qmul(s1_a_reg, s1_c2_reg);
    assign m_kc1 = qmul(s1_kt_reg, s1_c1_reg);
    assign m_kc2 = qmul(s1_kt_reg, s1_c2_reg);

    // stage 3 logic
    logic signed [31:0] inv_s, ds_s;
    qres_t m_i1, m_i2, n_t1, n_t2, n_k1, n_k2;
    assign inv_s = $signed({1'b0, cfg.inverse_step});
    assign ds_s  = $signed({1'b0, cfg.cell_step});
    assign m_i1  = qmul(s2_ac1_reg, inv_s);
    assign m_i2  = qmul(s2_ac2_reg, inv_s);
    assign n_t1  = qneg(m_i1.v, cfg.outer_side);
    assign n_t2  = qneg(m_i2.v, cfg.outer_side);
    assign n_k1  = qneg(s2_kc1_reg, cfg.outer_side);
    assign n_k2  = qneg(s2_kc2_reg, cfg.outer_side);

    // stage 4 logic: psi read-modify-write
    logic [63:0]        ram_rdata;
    logic               fwd;
    logic signed [31:0] old1, old2;
    qres_t bp1, bp2, np1, np2;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [63:0]        ram_wdata;

    assign fwd  = v_reg[4] && op_reg[4] == OP_UPDATE && ok_reg[4]
                  && addr_reg[4] == addr_reg[3];
    assign old1 = !ok_reg[3] ? 32'sd0 : (fwd ? s4_p1_reg : ram_rdata[63:32]);
    assign old2 = !ok_reg[3] ? 32'sd0 : (fwd ? s4_p2_reg : ram_rdata[31:0]);
    assign bp1  = qmul(s3_b_reg, old1);
    assign bp2  = qmul(s3_b_reg, old2);
    assign np1  = qadd(bp1.v, s3_t1_reg);
    assign np2  = qadd(bp2.v, s3_t2_reg);

    assign ram_we    = clr_reg || (v_reg[3] && op_reg[3] == OP_UPDATE && ok_reg[3]);
    assign ram_waddr = clr_reg ? clr_cnt_reg : addr_reg[3];
    assign ram_wdata = clr_reg ? 64'd0 : {np1.v, np2.v};

    cpmlu_ram #(
        .WIDTH(64),
        .DEPTH(PSI_DEPTH)
    ) u_psi_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg[2]),
        .rdata (ram_rdata)
    );

    // stage 5 logic
    qres_t m_d1, m_d2, in1, in2;
    assign m_d1 = qmul(ds_s, s4_p1_reg);
    assign m_d2 = qmul(ds_s, s4_p2_reg);
    assign in1  = qadd(s4_k1_reg, m_d1.v);
    assign in2  = qadd(s4_k2_reg, m_d2.v);

    // stage 6 logic
    qres_t m_c1, m_c2;
    assign m_c1 = qmul(cb1_reg[5], s5_i1_reg);
    assign m_c2 = qmul(cb2_reg[5], s5_i2_reg);

    // output
    qres_t o1, o2;
    assign o1 = cfg.magnetic_update ? qsub(f1_reg[6], s6_d1_reg)
                                    : qadd(f1_reg[6], s6_d1_reg);
    assign o2 = cfg.magnetic_update ? qadd(f2_reg[6], s6_d2_reg)
                                    : qsub(f2_reg[6], s6_d2_reg);

    assign push = v_reg[6];
    always_comb
    begin
        push_data = '0;
        if (op_reg[6] == OP_UPDATE)
        begin
            push_data.field1_out = o1.v;
            push_data.field2_out = o2.v;
            push_data.saturated  = clip_reg[6] | o1.clip | o2.clip;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= 6; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            v_reg[1] <= fire;
            for (int i = 2; i <= 6; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        // stage 1
        op_reg[1]   <= item.opcode;
        ok_reg[1]   <= cell_ok;
        addr_reg[1] <= AW'(item.cell_addr);
        f1_reg[1]   <= item.field1_in;
        f2_reg[1]   <= item.field2_in;
        cb1_reg[1]  <= item.cb_first;
        cb2_reg[1]  <= item.cb_second;
        s1_c1_reg   <= item.curl_first;
        s1_c2_reg   <= item.curl_second;
        s1_b_reg    <= layer_ok ? decay_reg[tidx] : 32'sd0;
        s1_a_reg    <= layer_ok ? scale_reg[tidx] : 32'sd0;
        s1_kt_reg   <= layer_ok ? kterm_reg[tidx] : 32'sd0;
        // pass-through
        for (int i = 2; i <= 6; i++)
        begin
            op_reg[i] <= op_reg[i-1];
            f1_reg[i] <= f1_reg[i-1];
            f2_reg[i] <= f2_reg[i-1];
        end
        for (int i = 2; i <= 4; i++)
        begin
            ok_reg[i]   <= ok_reg[i-1];
            addr_reg[i] <= addr_reg[i-1];
        end
        for (int i = 2; i <= 5; i++)
        begin
            cb1_reg[i] <= cb1_reg[i-1];
            cb2_reg[i] <= cb2_reg[i-1];
        end
        // stage 2
        s2_ac1_reg  <= m_ac1.v;
        s2_ac2_reg  <= m_ac2.v;
        s2_kc1_reg  <= m_kc1.v;
        s2_kc2_reg  <= m_kc2.v;
        s2_b_reg    <= s1_b_reg;
        clip_reg[2] <= m_ac1.clip | m_ac2.clip | m_kc1.clip | m_kc2.clip;
        // stage 3
        s3_t1_reg   <= n_t1.v;
        s3_t2_reg   <= n_t2.v;
        s3_k1_reg   <= n_k1.v;
        s3_k2_reg   <= n_k2.v;
        s3_b_reg    <= s2_b_reg;
        clip_reg[3] <= clip_reg[2] | m_i1.clip | m_i2.clip | n_t1.clip | n_t2.clip
                       | n_k1.clip | n_k2.clip;
        // stage 4
        s4_p1_reg   <= np1.v;
        s4_p2_reg   <= np2.v;
        s4_k1_reg   <= s3_k1_reg;
        s4_k2_reg   <= s3_k2_reg;
        clip_reg[4] <= clip_reg[3] | bp1.clip | bp2.clip | np1.clip | np2.clip;
        // stage 5
        s5_i1_reg   <= in1.v;
        s5_i2_reg   <= in2.v;
        clip_reg[5] <= clip_reg[4] | m_d1.clip | m_d2.clip | in1.clip | in2.clip;
        // stage 6
        s6_d1_reg   <= m_c1.v;
        s6_d2_reg   <= m_c2.v;
        clip_reg[6] <= clip_reg[5] | m_c1.clip | m_c2.clip;
    end
endmodule
